@@ rtl/core/spr_pkg.sv @@
// spr_pkg: shared constants, types and helpers of the session path ranker.
// No dependencies.
`default_nettype none
package spr_pkg;

	localparam int PATH_SLOTS = 4;
	localparam int SLOT_W     = $clog2(PATH_SLOTS);
	localparam int LABEL_W    = 64;
	localparam int METRIC_W   = 32;
	localparam int TIME_W     = 48;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEAD_LINK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NO_INFO   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;

	localparam logic CMD_DISCOVER = 1'b0;
	localparam logic CMD_START    = 1'b1;

	typedef struct packed {
		logic load;
		logic eval;
		logic update;
		logic rank;
		logic finish;
	} spr_cmd_t;

	function automatic logic [METRIC_W-1:0] eff_metric(
		input logic [TIME_W-1:0]   now,
		input logic [TIME_W-1:0]   then,
		input logic [METRIC_W-1:0] metric,
		input logic [METRIC_W-1:0] ceiling
	);
		logic [TIME_W-1:0] el;
		logic [TIME_W:0]   sum;
		el  = (now > then) ? (now - then) : '0;
		sum = {1'b0, el} + {{(TIME_W + 1 - METRIC_W){1'b0}}, metric};
		return (sum > {{(TIME_W + 1 - METRIC_W){1'b0}}, ceiling}) ? ceiling
			: sum[METRIC_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/session_path_ranker.sv @@
// session_path_ranker: path table of one routing session, top level.
// Instantiates spr_ctrl and spr_datapath; depends on spr_pkg.
// Steps: the input beat is taken in IDLE; evaluate, update, rank and finish follow;
// a new beat is taken only back in IDLE. A result held in the output register stalls
// the finish step, which loads the result register (not reset) and raises m_tvalid.
// Reset: arst_n clears table, flags, handshake state; config registers take defaults.
`default_nettype none
module session_path_ranker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // path_label, path_metric, now_ms
	input  wire logic [0:0]   s_tuser,  // command
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [95:0]       m_tdata,  // best_label, best_effective_metric
	output logic [2:0]        m_tuser,  // improved, announce, timed_out
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);

	spr_pkg::spr_cmd_t cmd;

	assign cfg_ready = 1'b1;

	spr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	spr_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.in_cmd    (s_tuser[0]),
		.out_data  (m_tdata),
		.out_flags (m_tuser)
	);

endmodule
`default_nettype wire

@@ rtl/core/spr_ctrl.sv @@
// spr_ctrl: sequencer of the session path ranker.
// Depends on spr_pkg.
`default_nettype none
module spr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output spr_pkg::spr_cmd_t      cmd
);

	typedef enum logic [2:0] {IDLE, EVAL, UPDATE, RANK, FIN} state_t;
	state_t state_q;

	logic out_free;
	assign out_free = !m_tvalid || m_tready;
	assign s_tready = (state_q == IDLE);

	always_comb begin
		cmd        = '0;
		cmd.load   = s_tvalid && s_tready;
		cmd.eval   = (state_q == EVAL);
		cmd.update = (state_q == UPDATE);
		cmd.rank   = (state_q == RANK);
		cmd.finish = (state_q == FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.finish)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
			unique case (state_q)
				IDLE: if (s_tvalid) state_q <= EVAL;
				EVAL: state_q <= UPDATE;
				UPDATE: state_q <= RANK;
				RANK: state_q <= FIN;
				FIN: if (out_free) state_q <= IDLE;
				default: state_q <= IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/spr_datapath.sv @@
// spr_datapath: path table, configuration registers and result register.
// Depends on spr_pkg.
`default_nettype none
module spr_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire spr_pkg::spr_cmd_t         cmd,
	input  wire logic                      cfg_valid,
	input  wire logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [spr_pkg::METRIC_W-1:0]  cfg_data,
	input  wire logic [143:0]              in_data,
	input  wire logic                      in_cmd,
	output logic [95:0]                    out_data,
	output logic [2:0]                     out_flags
);

	localparam int N  = spr_pkg::PATH_SLOTS;
	localparam int SW = spr_pkg::SLOT_W;
	localparam int LW = spr_pkg::LABEL_W;
	localparam int MW = spr_pkg::METRIC_W;
	localparam int TW = spr_pkg::TIME_W;

	logic [MW-1:0] dead_q, noinfo_q, tmo_q;
	logic          cmd_q;
	logic [LW-1:0] lbl_q;
	logic [MW-1:0] met_q;
	logic [TW-1:0] now_q;

	logic [LW-1:0] tl_q [N];
	logic [MW-1:0] tm_q [N];
	logic [TW-1:0] tt_q [N];
	logic [MW-1:0] em_q [N];
	logic          hit_q [N];
	logic          upd_q, new_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_q   <= '1;
			noinfo_q <= 32'hFFFF_FFF0;
			tmo_q    <= 32'd120000;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				spr_pkg::CFG_DEAD_LINK: dead_q <= cfg_data;
				spr_pkg::CFG_NO_INFO: noinfo_q <= cfg_data;
				spr_pkg::CFG_TIMEOUT: tmo_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// first match and worst slot
	logic          found;
	logic [SW-1:0] fi, wi;
	logic [MW-1:0] worst;
	always_comb begin
		found = 1'b0;
		fi    = '0;
		wi    = '0;
		worst = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_q[i] && !found) begin
				found = 1'b1;
				fi    = SW'(i);
			end
			if (em_q[i] > worst) begin
				worst = em_q[i];
				wi    = SW'(i);
			end
		end
	end

	logic [MW-1:0] best;
	logic [SW-1:0] bi;
	always_comb begin
		best = dead_q;
		bi   = '0;
		for (int i = 0; i < N; i++) begin
			if (em_q[i] < best) begin
				best = em_q[i];
				bi   = SW'(i);
			end
		end
	end

	logic [TW-1:0] newest;
	always_comb begin
		newest = '0;
		for (int i = 0; i < N; i++)
			if (tt_q[i] > newest) newest = tt_q[i];
	end

	logic [MW-1:0] met_eff;
	logic [TW-1:0] nel;
	assign met_eff = (met_q > noinfo_q) ? noinfo_q : met_q;
	assign nel     = (now_q > newest) ? (now_q - newest) : '0;

	logic          sel_ok;
	logic [SW-1:0] sel;
	assign sel    = found ? fi : wi;
	assign sel_ok = found ? (met_q == dead_q || em_q[fi] > met_q) : (em_q[wi] > met_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				tl_q[i]  <= '0;
				tm_q[i]  <= '0;
				tt_q[i]  <= '0;
				em_q[i]  <= '0;
				hit_q[i] <= 1'b0;
			end
			upd_q <= 1'b0;
			new_q <= 1'b0;
			cmd_q <= 1'b0;
			lbl_q <= '0;
			met_q <= '0;
			now_q <= '0;
		end else begin
			if (cmd.load) begin
				cmd_q <= in_cmd;
				lbl_q <= in_data[LW-1:0];
				met_q <= in_data[LW+MW-1:LW];
				now_q <= in_data[LW+MW+TW-1:LW+MW];
			end
			if (cmd.eval) begin
				for (int i = 0; i < N; i++) begin
					em_q[i]  <= spr_pkg::eff_metric(now_q, tt_q[i], tm_q[i], noinfo_q);
					hit_q[i] <= (tl_q[i] == lbl_q);
				end
			end
			if (cmd.update) begin
				upd_q <= 1'b0;
				new_q <= 1'b0;
				if (cmd_q == spr_pkg::CMD_START) begin
					for (int i = 0; i < N; i++) begin
						tl_q[i] <= '0;
						tm_q[i] <= '0;
						tt_q[i] <= '0;
					end
					tl_q[0] <= lbl_q;
					tm_q[0] <= (lbl_q != '0) ? met_q : dead_q;
					tt_q[0] <= now_q;
				end else if (lbl_q != '0 && sel_ok) begin
					tl_q[sel] <= lbl_q;
					tm_q[sel] <= met_q;
					tt_q[sel] <= now_q;
					em_q[sel] <= met_eff;
					upd_q     <= 1'b1;
					new_q     <= !found;
				end
			end
			if (cmd.rank && upd_q && bi != '0) begin
				tl_q[0]  <= tl_q[bi];
				tm_q[0]  <= tm_q[bi];
				tt_q[0]  <= tt_q[bi];
				em_q[0]  <= em_q[bi];
				tl_q[bi] <= tl_q[0];
				tm_q[bi] <= tm_q[0];
				tt_q[bi] <= tt_q[0];
				em_q[bi] <= em_q[0];
			end
		end
	end

	logic imp, ann;
	always_comb begin
		if (cmd_q == spr_pkg::CMD_START) begin
			imp = (lbl_q != '0);
			ann = 1'b1;
		end else begin
			imp = upd_q && (tl_q[0] == lbl_q);
			ann = imp && new_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data[LW-1:0]     <= tl_q[0];
			out_data[LW+MW-1:LW] <= spr_pkg::eff_metric(now_q, tt_q[0], tm_q[0], noinfo_q);
			out_flags[0]         <= imp;
			out_flags[1]         <= ann;
			out_flags[2]         <= (nel > {{(TW - MW){1'b0}}, tmo_q});
		end
	end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for session_path_ranker: a stream driver and monitor
// check every result beat against an in-bench model of the path table.
// Depends on spr_pkg and the session_path_ranker RTL.
`timescale 1ns / 100ps
module testbench;
	import spr_pkg::*;

	typedef struct packed {
		logic                cmd;
		logic [LABEL_W-1:0]  label;
		logic [METRIC_W-1:0] metric;
		logic [TIME_W-1:0]   now;
	} path_item_t;

	typedef struct packed {
		logic                improved;
		logic                announce;
		logic [LABEL_W-1:0]  best_label;
		logic [METRIC_W-1:0] best_eff;
		logic                timed_out;
	} rank_result_t;

	logic clk = 0, arst_n = 0;
	logic s_tvalid = 0, m_tready = 0, cfg_valid = 0;
	logic [143:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic s_tready, m_tvalid, cfg_ready;
	logic [95:0] m_tdata;
	logic [2:0] m_tuser;

	session_path_ranker dut (.*);

	initial forever #5 clk = ~clk;

	// model state
	logic [LABEL_W-1:0]  tbl_label[PATH_SLOTS];
	logic [METRIC_W-1:0] tbl_metric[PATH_SLOTS];
	logic [TIME_W-1:0]   tbl_time[PATH_SLOTS];
	logic [METRIC_W-1:0] dead_m = 32'hFFFFFFFF, noinfo_m = 32'hFFFFFFF0, tmo = 120000;

	path_item_t   pending_items[$];
	rank_result_t expected_ranks[$];
	int errors = 0, n_sent = 0, n_seen = 0, n_start = 0, n_announce = 0;
	int stall_hold = 0;
	bit pause_drv = 0;
	longint cycles = 0;
	logic [TIME_W-1:0] clock_ms = 0;

	function automatic logic [METRIC_W-1:0] slot_eff(int s, logic [TIME_W-1:0] now);
		logic [TIME_W:0] x;
		x = ((now > tbl_time[s]) ? {1'b0, now - tbl_time[s]} : '0) + tbl_metric[s];
		return (x > noinfo_m) ? noinfo_m : x[METRIC_W-1:0];
	endfunction

	task automatic rerank_table(logic [TIME_W-1:0] now);
		logic [METRIC_W-1:0] best;
		int bi;
		logic [LABEL_W-1:0] l;
		logic [METRIC_W-1:0] m;
		logic [TIME_W-1:0] t;
		best = dead_m;
		bi = 0;
		for (int i = 0; i < PATH_SLOTS; i++)
			if (slot_eff(i, now) < best) begin
				best = slot_eff(i, now);
				bi = i;
			end
		if (bi != 0) begin
			l = tbl_label[0]; m = tbl_metric[0]; t = tbl_time[0];
			tbl_label[0] = tbl_label[bi]; tbl_metric[0] = tbl_metric[bi];
			tbl_time[0] = tbl_time[bi];
			tbl_label[bi] = l; tbl_metric[bi] = m; tbl_time[bi] = t;
		end
	endtask

	task automatic rank_path(path_item_t it);
		rank_result_t r;
		int found, wi, ni;
		logic [METRIC_W-1:0] worst;
		logic [TIME_W-1:0] newest;
		r = '0;
		if (it.cmd == CMD_START) begin
			for (int i = 0; i < PATH_SLOTS; i++) begin
				tbl_label[i] = '0; tbl_metric[i] = '0; tbl_time[i] = '0;
			end
			tbl_label[0] = it.label;
			tbl_metric[0] = (it.label != 0) ? it.metric : dead_m;
			tbl_time[0] = it.now;
			r.improved = (it.label != 0);
			r.announce = 1;
		end else if (it.label != 0) begin
			found = -1;
			for (int i = PATH_SLOTS - 1; i >= 0; i--)
				if (tbl_label[i] == it.label) found = i;
			if (found >= 0) begin
				if (it.metric == dead_m || slot_eff(found, it.now) > it.metric) begin
					tbl_metric[found] = it.metric;
					tbl_time[found] = it.now;
					rerank_table(it.now);
					r.improved = (tbl_label[0] == it.label);
				end
			end else begin
				worst = 0;
				wi = 0;
				for (int i = 0; i < PATH_SLOTS; i++)
					if (slot_eff(i, it.now) > worst) begin
						worst = slot_eff(i, it.now);
						wi = i;
					end
				if (slot_eff(wi, it.now) > it.metric) begin
					tbl_label[wi] = it.label; tbl_metric[wi] = it.metric;
					tbl_time[wi] = it.now;
					rerank_table(it.now);
					if (tbl_label[0] == it.label) begin
						r.improved = 1;
						r.announce = 1;
					end
				end
			end
		end
		newest = 0;
		ni = 0;
		for (int i = 0; i < PATH_SLOTS; i++)
			if (tbl_time[i] > newest) begin
				newest = tbl_time[i];
				ni = i;
			end
		r.best_label = tbl_label[0];
		r.best_eff = slot_eff(0, it.now);
		r.timed_out = ((it.now > tbl_time[ni]) ? (it.now - tbl_time[ni]) : 48'd0) > tmo;
		expected_ranks.push_back(r);
	endtask

	// driver
	int drv_gap = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				n_sent++;
				drv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			end
			if (!(s_tvalid && !s_tready)) begin
				if (drv_gap > 0) begin
					drv_gap--;
					s_tvalid <= 0;
				end else if (!pause_drv && pending_items.size() > 0) begin
					path_item_t it;
					it = pending_items.pop_front();
					rank_path(it);
					s_tdata <= {it.now, it.metric, it.label};
					s_tuser <= it.cmd;
					s_tvalid <= 1;
				end else s_tvalid <= 0;
			end
		end
	end

	// monitor
	int mon_gap = 0;
	always @(posedge clk) begin
		cycles++;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				rank_result_t exp_r;
				n_seen++;
				if (expected_ranks.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_r = expected_ranks.pop_front();
					if (exp_r.announce) n_announce++;
					if (m_tuser[0] !== exp_r.improved) begin
						$error("improved exp %0d got %0d", exp_r.improved, m_tuser[0]);
						errors++;
					end
					if (m_tuser[1] !== exp_r.announce) begin
						$error("announce exp %0d got %0d", exp_r.announce, m_tuser[1]);
						errors++;
					end
					if (m_tuser[2] !== exp_r.timed_out) begin
						$error("timed_out exp %0d got %0d", exp_r.timed_out, m_tuser[2]);
						errors++;
					end
					if (m_tdata[63:0] !== exp_r.best_label) begin
						$error("best_label exp %h got %h", exp_r.best_label, m_tdata[63:0]);
						errors++;
					end
					if (m_tdata[95:64] !== exp_r.best_eff) begin
						$error("best_effective_metric exp %h got %h", exp_r.best_eff,
							m_tdata[95:64]);
						errors++;
					end
				end
				mon_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			end
			if (stall_hold > 0) begin
				stall_hold--;
				m_tready <= 0;
			end else if (mon_gap > 0) begin
				mon_gap--;
				m_tready <= 0;
			end else m_tready <= 1;
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_DEAD_LINK: dead_m = val;
			CFG_NO_INFO:   noinfo_m = val;
			CFG_TIMEOUT:   tmo = val;
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || expected_ranks.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [LABEL_W-1:0] pick_label();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return {$urandom, $urandom};
			default: return $urandom_range(1, 6);
		endcase
	endfunction

	function automatic logic [METRIC_W-1:0] pick_metric();
		case ($urandom_range(0, 7))
			0: return dead_m;
			1: return $urandom;
			2: return 32'hFFFFFFFF;
			default: return $urandom_range(0, 5000);
		endcase
	endfunction

	function automatic path_item_t rand_item();
		path_item_t it;
		it.cmd = ($urandom_range(0, 19) == 0) ? CMD_START : CMD_DISCOVER;
		it.label = pick_label();
		it.metric = pick_metric();
		case ($urandom_range(0, 9))
			0: it.now = clock_ms - $urandom_range(0, 3000);
			1: it.now = clock_ms + $urandom_range(100000, 200000);
			default: it.now = clock_ms + $urandom_range(0, 2000);
		endcase
		if (it.now > clock_ms) clock_ms = it.now;
		return it;
	endfunction

	function automatic path_item_t mk(logic c, logic [63:0] l, logic [31:0] m, logic [47:0] t);
		path_item_t it;
		it.cmd = c; it.label = l; it.metric = m; it.now = t;
		return it;
	endfunction

	initial begin
		for (int i = 0; i < PATH_SLOTS; i++) begin
			tbl_label[i] = '0; tbl_metric[i] = '0; tbl_time[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed
		pending_items.push_back(mk(CMD_DISCOVER, 64'd5, 32'd10, 48'd0));
		pending_items.push_back(mk(CMD_START, 64'd0, 32'd7, 48'd10));
		pending_items.push_back(mk(CMD_START, 64'd1, 32'd100, 48'd20));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd0, 32'd1, 48'd21));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd2, 32'd50, 48'd22));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd3, 32'd500, 48'd23));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd2, 32'd60, 48'd24));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd2, 32'd1, 48'd25));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd1, 32'hFFFFFFFF, 48'd26));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd4, 32'd0, 48'd15));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd6, 32'hFFFFFFFF, 48'd30));
		pending_items.push_back(mk(CMD_DISCOVER, '1, 32'd0, 48'd200000));
		pending_items.push_back(mk(CMD_START, '1, '1, '1));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd9, 32'd3, '1));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd9, 32'd3, 48'd0));
		pending_items.push_back(mk(CMD_START, 64'h8000000000000000, 32'h80000000,
			48'h800000000000));
		pending_items.push_back(mk(CMD_DISCOVER, 64'd7, 32'd1, 48'h800000100000));
		clock_ms = 48'h800000100000 - 48'h7F0000000000;
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin cfg_write(CFG_DEAD_LINK, 32'd3000); cfg_write(CFG_TIMEOUT, 32'd0); end
				1: begin cfg_write(CFG_NO_INFO, 32'd2500); cfg_write(CFG_TIMEOUT, 32'd1500); end
				2: begin cfg_write(CFG_DEAD_LINK, 32'd0); cfg_write(CFG_NO_INFO, 32'd0); end
				3: begin cfg_write(CFG_DEAD_LINK, '1); cfg_write(CFG_NO_INFO, '1);
					cfg_write(CFG_TIMEOUT, '1); end
				4: begin cfg_write(CFG_NO_INFO, $urandom); cfg_write(CFG_TIMEOUT, $urandom); end
				default: begin cfg_write(CFG_DEAD_LINK, 32'hFFFFFFFF);
					cfg_write(CFG_NO_INFO, 32'hFFFFFFF0); cfg_write(CFG_TIMEOUT, 32'd120000); end
			endcase
			pending_items.push_back(mk(CMD_START, pick_label() | 1, pick_metric(), clock_ms));
			for (int k = 0; k < 320; k++) pending_items.push_back(rand_item());
			if (ph == 2) begin
				while (pending_items.size() > 250) @(posedge clk);
				stall_hold = 300;
			end
			if (ph == 4) begin
				while (pending_items.size() > 160) @(posedge clk);
				pause_drv = 1;
				while (expected_ranks.size() > 0 || s_tvalid) @(posedge clk);
				repeat (20) @(posedge clk);
				pause_drv = 0;
			end
			drain();
		end
		$display("Sent %0d path beats, checked %0d results, %0d announce events.",
			n_sent, n_seen, n_announce);
		$display("Six register settings covered, including extreme values.");
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		while (cycles < 400000) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end
endmodule
